@@ src/gsca_pkg.sv @@
`timescale 1ns / 1ps
package gsca_pkg;

	localparam int MAX_ENTRIES = 512;
	localparam int INDEX_BITS  = 20;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int READ_W      = 9;
	localparam int TALLY_W     = 16;
	localparam int GRP_SIZE    = 16;
	localparam int NUM_GRP     = MAX_ENTRIES / GRP_SIZE;

	localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

	typedef logic [INDEX_BITS-1:0] key_t;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_TOGGLE = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_OVERFLOW = 2'd1,
		STATUS_RANGE    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_CMP,
		FSM_COMMIT
	} fsm_t;

	typedef struct packed {
		logic load;
		logic commit;
	} ctrl_t;

	typedef struct packed {
		logic ins;
		logic del;
	} shift_t;

endpackage

@@ src/gsca_cell.sv @@
`timescale 1ns / 1ps
module gsca_cell import gsca_pkg::*; (
	input  logic             clk,
	input  logic [IDX_W-1:0] idx,
	input  key_t             key,
	input  logic [IDX_W-1:0] rd,
	input  logic             is_read,
	input  logic [CNT_W-1:0] count,
	input  shift_t           shift,
	input  key_t             left_entry,
	input  logic             left_lt,
	input  key_t             right_entry,
	output key_t             entry,
	output logic             lt,
	output logic             hit,
	output key_t             hit_data
);

	key_t entry_q;
	logic occupied;

	assign occupied = CNT_W'(idx) < count;
	assign lt       = occupied && (entry_q < key);
	assign hit      = is_read ? (idx == rd) : (occupied && (entry_q == key));
	assign hit_data = hit ? entry_q : '0;
	assign entry    = entry_q;

	// cells at or above the sorted position move: right on insert, left on delete
	always_ff @(posedge clk) begin
		if (shift.ins && !lt) begin
			entry_q <= left_lt ? key : left_entry;
		end else if (shift.del && !lt) begin
			entry_q <= right_entry;
		end
	end

endmodule

@@ src/gsca_group.sv @@
`timescale 1ns / 1ps
module gsca_group import gsca_pkg::*; (
	input  logic                                clk,
	input  logic [GRP_SIZE-1:0]                 hit,
	input  logic [GRP_SIZE-1:0][INDEX_BITS-1:0] data,
	output logic                                hit_s2,
	output key_t                                data_s2
);

	key_t data_or;

	always_comb begin
		data_or = '0;
		for (int i = 0; i < GRP_SIZE; i++) begin
			data_or = data_or | data[i];
		end
	end

	always_ff @(posedge clk) begin
		hit_s2  <= |hit;
		data_s2 <= data_or;
	end

endmodule

@@ src/gsca_ctrl.sv @@
`timescale 1ns / 1ps
module gsca_ctrl import gsca_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	output ctrl_t ctrl
);

	fsm_t state_q;
	fsm_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		busy    = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = FSM_CMP;
				end
			end
			FSM_CMP: begin
				busy    = 1'b1;
				state_d = FSM_COMMIT;
			end
			FSM_COMMIT: begin
				ctrl.commit = 1'b1;
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = FSM_CMP;
				end else begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

endmodule

@@ src/gf2_sparse_column_accumulator.sv @@
`timescale 1ns / 1ps
// A word accepted at a clock edge passes the compare cycle, the reduce/commit cycle
// and the output register before its result is strobed on done. busy is high in the
// compare cycle, so the next word is taken in the commit cycle of the last one at the
// earliest; that commit shifts the cell row. The receiver cannot stall.
// Reset (arst_n low, async): weight, relation count, FSM and done clear; the
// stored entries stay undefined, only positions below the weight are ever used.
module gf2_sparse_column_accumulator import gsca_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            op,
	input  logic [INDEX_BITS-1:0] factor_index,
	input  logic                  last_in_relation,
	input  logic [READ_W-1:0]     read_index,
	output logic                  busy,
	output logic                  done,
	output logic [1:0]            status,
	output logic [CNT_W-1:0]      column_weight,
	output logic [INDEX_BITS-1:0] entry_value,
	output logic                  was_present,
	output logic [TALLY_W-1:0]    relations_merged
);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	ctrl_t ctrl;

	gsca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	// ---------------------------------------------------------------
	// Command word, held for the compare and commit cycles
	// ---------------------------------------------------------------
	op_t               op_q;
	key_t              key_q;
	logic              last_q;
	logic [READ_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			op_q   <= op_t'(op);
			key_q  <= factor_index;
			last_q <= last_in_relation;
			rd_q   <= read_index;
		end
	end

	// column state
	logic [CNT_W-1:0]   count_q;
	logic [TALLY_W-1:0] tally_q;

	// ---------------------------------------------------------------
	// Cell row: cell i holds the i-th smallest index. All cells compare
	// against the broadcast key; on a commit each cell at or past the
	// sorted position takes left neighbor or key (insert), right neighbor
	// (delete). Cell 0 sees a left neighbor that is always "less than".
	// ---------------------------------------------------------------
	logic [MAX_ENTRIES-1:0][INDEX_BITS-1:0] entry;
	logic [MAX_ENTRIES-1:0][INDEX_BITS-1:0] hit_data;
	logic [MAX_ENTRIES-1:0]                 lt;
	logic [MAX_ENTRIES-1:0]                 hit;
	shift_t                                 shift;
	logic                                   is_read;

	assign is_read = (op_q == OP_READ);

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		key_t left_entry;
		key_t right_entry;
		logic left_lt;

		if (i == 0) begin : g_first
			assign left_entry = '0;
			assign left_lt    = 1'b1;
		end else begin : g_mid
			assign left_entry = entry[i-1];
			assign left_lt    = lt[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_inner
			assign right_entry = entry[i+1];
		end

		gsca_cell u_cell (
			.clk         (clk),
			.idx         (IDX_W'(i)),
			.key         (key_q),
			.rd          (rd_q[IDX_W-1:0]),
			.is_read     (is_read),
			.count       (count_q),
			.shift       (shift),
			.left_entry  (left_entry),
			.left_lt     (left_lt),
			.right_entry (right_entry),
			.entry       (entry[i]),
			.lt          (lt[i]),
			.hit         (hit[i]),
			.hit_data    (hit_data[i])
		);
	end

	// ---------------------------------------------------------------
	// Match reduction: 16-cell groups registered, then a short OR over
	// the group results in the commit cycle. Toggle uses the hit bit
	// (index present), read uses the data of the addressed cell.
	// ---------------------------------------------------------------
	logic [NUM_GRP-1:0] grp_hit_s2;
	key_t               grp_data_s2 [NUM_GRP];

	for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
		gsca_group u_group (
			.clk     (clk),
			.hit     (hit[g*GRP_SIZE +: GRP_SIZE]),
			.data    (hit_data[g*GRP_SIZE +: GRP_SIZE]),
			.hit_s2  (grp_hit_s2[g]),
			.data_s2 (grp_data_s2[g])
		);
	end

	logic found;
	key_t read_data;

	assign found = |grp_hit_s2;

	always_comb begin
		read_data = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			read_data = read_data | grp_data_s2[g];
		end
	end

	// ---------------------------------------------------------------
	// Commit: update weight and relation count, form the result word
	// ---------------------------------------------------------------
	logic               full;
	logic               is_toggle;
	logic               rd_in_range;
	logic [CNT_W-1:0]   count_d;
	logic [TALLY_W-1:0] tally_d;
	status_t            status_d;
	key_t               value_d;

	assign full        = (count_q == CNT_W'(MAX_ENTRIES));
	assign is_toggle   = (op_q == OP_TOGGLE);
	assign rd_in_range = (CNT_W'(rd_q) < count_q);
	assign shift.del   = ctrl.commit && is_toggle && found;
	assign shift.ins   = ctrl.commit && is_toggle && !found && !full;

	always_comb begin
		count_d  = count_q;
		tally_d  = tally_q;
		status_d = STATUS_OK;
		value_d  = '0;
		unique case (op_q)
			OP_CLEAR: begin
				count_d = '0;
				tally_d = '0;
			end
			OP_TOGGLE: begin
				if (found) begin
					count_d = count_q - CNT_W'(1);
				end else if (full) begin
					status_d = STATUS_OVERFLOW;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
				if (last_q && (tally_q != TALLY_MAX)) begin
					tally_d = tally_q + TALLY_W'(1);
				end
			end
			OP_READ: begin
				if (rd_in_range) begin
					value_d = read_data;
				end else begin
					status_d = STATUS_RANGE;
				end
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tally_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= ctrl.commit;
			if (ctrl.commit) begin
				count_q <= count_d;
				tally_q <= tally_d;
			end
		end
	end

	// result word registers, valid while done is high
	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			status           <= status_d;
			column_weight    <= count_d;
			entry_value      <= value_d;
			was_present      <= is_toggle && found;
			relations_merged <= tally_d;
		end
	end

endmodule

@@ src/gsca_checker.sv @@
`timescale 1ns / 1ps
module gsca_checker import gsca_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic [1:0]            status,
	input logic [CNT_W-1:0]      column_weight,
	input logic [INDEX_BITS-1:0] entry_value,
	input logic                  was_present,
	input logic [TALLY_W-1:0]    relations_merged
);

	// every accepted word gets its result strobed on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result strobe missing after accepted word");

	a_weight_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> column_weight <= CNT_W'(MAX_ENTRIES))
		else $error("column weight above capacity");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_OVERFLOW) |->
			(column_weight == CNT_W'(MAX_ENTRIES)) && !was_present)
		else $error("overflow reported on a column that is not full");

	a_removed: assert property (@(posedge clk) disable iff (!arst_n)
		done && was_present |-> (status == STATUS_OK) && (entry_value == '0))
		else $error("removal word carries bad status or data");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_RANGE) |-> (entry_value == '0) && !was_present)
		else $error("out of range read returned data");

endmodule

bind gf2_sparse_column_accumulator gsca_checker u_gsca_checker (.*);

@@ sim/gf2_sparse_column_accumulator_tb.sv @@
`timescale 1ns / 1ps
module gf2_sparse_column_accumulator_tb;
	import gsca_pkg::*;

	// Generous guard: even with the longest idle gap ahead of every word a
	// correct run stays well under this limit.
	localparam int LIMIT_CYCLES = 1000000;
	localparam int BURST_WORDS  = 24;
	localparam int POOL_SIZE    = 16;
	localparam int DIR_ROWS     = 24;

	// One result word as the block reports it.
	typedef struct packed {
		logic [1:0]         status;
		logic [CNT_W-1:0]   weight;
		key_t               value;
		logic               removed;
		logic [TALLY_W-1:0] tally;
	} column_result_t;

	// Directed stimulus row; typed rows carry a result read straight off the spec.
	typedef struct {
		op_t                op;
		key_t               key;
		logic               last;
		logic [READ_W-1:0]  rd;
		bit                 typed;
		column_result_t     want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic [1:0]            op;
	logic [INDEX_BITS-1:0] factor_index;
	logic                  last_in_relation;
	logic [READ_W-1:0]     read_index;
	logic                  busy;
	logic                  done;
	logic [1:0]            status;
	logic [CNT_W-1:0]      column_weight;
	logic [INDEX_BITS-1:0] entry_value;
	logic                  was_present;
	logic [TALLY_W-1:0]    relations_merged;

	gf2_sparse_column_accumulator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.op               (op),
		.factor_index     (factor_index),
		.last_in_relation (last_in_relation),
		.read_index       (read_index),
		.busy             (busy),
		.done             (done),
		.status           (status),
		.column_weight    (column_weight),
		.entry_value      (entry_value),
		.was_present      (was_present),
		.relations_merged (relations_merged)
	);

	// Shadow copy of the column: sorted unique keys, weight and relation tally.
	key_t           shadow_col [MAX_ENTRIES];
	int             shadow_cnt;
	int             shadow_tally;
	column_result_t pending_results [$];
	key_t           key_pool [POOL_SIZE];
	int             errors;
	int             cycles;
	bit             no_idle;
	int             calm_left;

	// Short table: reset state, both key extremes, every op, read past weight,
	// removal, clear with last set, and the unused op.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{OP_READ,   20'h00000, 1'b0, 9'h000, 1'b1, '{STATUS_RANGE, 10'd0, 20'h0, 1'b0, 16'd0}},
		'{OP_NOP,    20'hFFFFF, 1'b1, 9'h1FF, 1'b1, '{STATUS_OK, 10'd0, 20'h0, 1'b0, 16'd0}},
		'{OP_TOGGLE, 20'hFFFFF, 1'b0, 9'h000, 1'b1, '{STATUS_OK, 10'd1, 20'h0, 1'b0, 16'd0}},
		'{OP_TOGGLE, 20'h00000, 1'b1, 9'h1FF, 1'b1, '{STATUS_OK, 10'd2, 20'h0, 1'b0, 16'd1}},
		'{OP_READ,   20'hFFFFF, 1'b0, 9'h000, 1'b1, '{STATUS_OK, 10'd2, 20'h0, 1'b0, 16'd1}},
		'{OP_READ,   20'h00000, 1'b1, 9'h001, 1'b1,
			'{STATUS_OK, 10'd2, 20'hFFFFF, 1'b0, 16'd1}},
		'{OP_READ,   20'h00000, 1'b0, 9'h002, 1'b1, '{STATUS_RANGE, 10'd2, 20'h0, 1'b0, 16'd1}},
		'{OP_READ,   20'h00000, 1'b0, 9'h1FF, 1'b1, '{STATUS_RANGE, 10'd2, 20'h0, 1'b0, 16'd1}},
		'{OP_TOGGLE, 20'hFFFFF, 1'b1, 9'h000, 1'b1, '{STATUS_OK, 10'd1, 20'h0, 1'b1, 16'd2}},
		'{OP_TOGGLE, 20'h55555, 1'b0, 9'h0AA, 1'b0, '0},
		'{OP_TOGGLE, 20'hAAAAA, 1'b0, 9'h155, 1'b0, '0},
		'{OP_TOGGLE, 20'h12345, 1'b1, 9'h000, 1'b0, '0},
		'{OP_TOGGLE, 20'h55555, 1'b0, 9'h000, 1'b0, '0},
		'{OP_READ,   20'h00000, 1'b0, 9'h000, 1'b0, '0},
		'{OP_READ,   20'h00000, 1'b0, 9'h001, 1'b0, '0},
		'{OP_READ,   20'h00000, 1'b0, 9'h002, 1'b0, '0},
		'{OP_READ,   20'h00000, 1'b0, 9'h0AA, 1'b0, '0},
		'{OP_READ,   20'hFFFFF, 1'b1, 9'h155, 1'b0, '0},
		'{OP_CLEAR,  20'hFFFFF, 1'b1, 9'h1FF, 1'b1, '{STATUS_OK, 10'd0, 20'h0, 1'b0, 16'd0}},
		'{OP_TOGGLE, 20'h00000, 1'b0, 9'h000, 1'b0, '0},
		'{OP_TOGGLE, 20'h00000, 1'b1, 9'h000, 1'b0, '0},
		'{OP_READ,   20'h00000, 1'b0, 9'h000, 1'b0, '0},
		'{OP_CLEAR,  20'h00000, 1'b0, 9'h000, 1'b1, '{STATUS_OK, 10'd0, 20'h0, 1'b0, 16'd0}},
		'{OP_NOP,    20'h00000, 1'b0, 9'h000, 1'b0, '0}
	};

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Predict one word: toggles keep the column sorted, a full column refuses
	// inserts, the relation tally saturates.
	function automatic column_result_t accumulate_word(op_t w_op, key_t key, logic last,
			logic [READ_W-1:0] rd);
		column_result_t r;
		int pos;
		int i;
		r = '0;
		r.status = STATUS_OK;
		case (w_op)
			OP_CLEAR: begin
				shadow_cnt   = 0;
				shadow_tally = 0;
			end
			OP_TOGGLE: begin
				pos = 0;
				while (pos < shadow_cnt && shadow_col[pos] < key)
					pos++;
				if (pos < shadow_cnt && shadow_col[pos] == key) begin
					for (i = pos; i < shadow_cnt - 1; i++)
						shadow_col[i] = shadow_col[i + 1];
					shadow_cnt--;
					r.removed = 1'b1;
				end else if (shadow_cnt >= MAX_ENTRIES) begin
					r.status = STATUS_OVERFLOW;
				end else begin
					for (i = shadow_cnt; i > pos; i--)
						shadow_col[i] = shadow_col[i - 1];
					shadow_col[pos] = key;
					shadow_cnt++;
				end
				// counts even when the insert was refused
				if (last && shadow_tally < int'(TALLY_MAX))
					shadow_tally++;
			end
			OP_READ: begin
				if (int'(rd) < shadow_cnt)
					r.value = shadow_col[rd];
				else
					r.status = STATUS_RANGE;
			end
			default: ;
		endcase
		r.weight = shadow_cnt[CNT_W-1:0];
		r.tally  = shadow_tally[TALLY_W-1:0];
		return r;
	endfunction

	function automatic bit column_holds(key_t key);
		int i;
		for (i = 0; i < shadow_cnt; i++)
			if (shadow_col[i] == key)
				return 1'b1;
		return 1'b0;
	endfunction

	// Mostly short gaps, a few long ones, and now and then a calm stretch.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(10, 40);
	endfunction

	function automatic key_t pick_key();
		if ($urandom_range(0, 9) < 6)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return key_t'($urandom_range(0, (1 << INDEX_BITS) - 1));
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	// Drive one word at the falling edge and hold it until an edge sees busy low.
	// With no gap, start stays high across back-to-back words.
	task automatic issue_word(input op_t w_op, input key_t key, input logic last,
			input logic [READ_W-1:0] rd, input bit typed, input column_result_t want);
		int gap;
		column_result_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start            = 1'b1;
		op               = w_op;
		factor_index     = key;
		last_in_relation = last;
		read_index       = rd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = accumulate_word(w_op, key, last, rd);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Relations of a few indices from a small pool, so keys cancel often,
	// mixed with reads, clears, broken relations and unused-op noise.
	task automatic random_traffic(input int n_words);
		int sent;
		int pick;
		int len;
		int j;
		int rd_hi;
		logic last;
		sent = 0;
		while (sent < n_words) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				len = $urandom_range(1, 8);
				for (j = 0; j < len; j++) begin
					last = (j == len - 1);
					if (last && $urandom_range(0, 9) == 0)
						last = 1'b0;  // relation cut short
					issue_word(OP_TOGGLE, pick_key(), last, READ_W'($urandom), 1'b0, '0);
				end
				sent += len;
			end else if (pick < 85) begin
				rd_hi = (shadow_cnt + 1 > 511) ? 511 : shadow_cnt + 1;
				if ($urandom_range(0, 3) == 0)
					rd_hi = 511;
				issue_word(OP_READ, key_t'($urandom), 1'($urandom),
					READ_W'($urandom_range(0, rd_hi)), 1'b0, '0);
				sent++;
			end else if (pick < 93) begin
				issue_word(OP_NOP, key_t'($urandom), 1'($urandom), READ_W'($urandom),
					1'b0, '0);
				sent++;
			end else if (pick < 97) begin
				issue_word(OP_CLEAR, key_t'($urandom), 1'($urandom), READ_W'($urandom),
					1'b0, '0);
				sent++;
			end else begin
				issue_word(OP_TOGGLE, key_t'($urandom), 1'($urandom), READ_W'($urandom),
					1'b0, '0);
				sent++;
			end
		end
	endtask

	// Results come one cycle wide on done; each one retires the oldest prediction.
	always @(posedge clk) begin
		column_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status)
					report_mismatch("status", status, exp_r.status);
				if (column_weight !== exp_r.weight)
					report_mismatch("column_weight", column_weight, exp_r.weight);
				if (entry_value !== exp_r.value)
					report_mismatch("entry_value", entry_value, exp_r.value);
				if (was_present !== exp_r.removed)
					report_mismatch("was_present", was_present, exp_r.removed);
				if (relations_merged !== exp_r.tally)
					report_mismatch("relations_merged", relations_merged, exp_r.tally);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int i;
		key_t key;
		start            = 1'b0;
		op               = OP_NOP;
		factor_index     = '0;
		last_in_relation = 1'b0;
		read_index       = '0;
		arst_n           = 1'b0;
		errors           = 0;
		cycles           = 0;
		no_idle          = 1'b0;
		calm_left        = 0;
		shadow_cnt       = 0;
		shadow_tally     = 0;
		key_pool[0]      = '0;
		key_pool[1]      = '1;
		for (i = 2; i < POOL_SIZE; i++)
			key_pool[i] = key_t'($urandom);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < DIR_ROWS; i++)
			issue_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].last, dir_rows[i].rd,
				dir_rows[i].typed, dir_rows[i].want);

		// Fill the column to capacity with distinct random keys, with a few
		// reads and relation ends scattered in.
		issue_word(OP_CLEAR, '0, 1'b0, '0, 1'b0, '0);
		while (shadow_cnt < MAX_ENTRIES) begin
			do
				key = key_t'($urandom);
			while (column_holds(key));
			issue_word(OP_TOGGLE, key, ($urandom_range(0, 7) == 0), READ_W'($urandom),
				1'b0, '0);
			if ($urandom_range(0, 15) == 0)
				issue_word(OP_READ, '0, 1'b0, READ_W'($urandom_range(0, shadow_cnt)),
					1'b0, '0);
		end

		// Full column: refused inserts (with and without relation end), reads
		// at both ends, removal and re-insert.
		for (i = 0; i < 4; i++) begin
			do
				key = key_t'($urandom);
			while (column_holds(key));
			issue_word(OP_TOGGLE, key, 1'(i), '0, 1'b0, '0);
		end
		issue_word(OP_READ, '0, 1'b0, 9'h1FF, 1'b0, '0);
		issue_word(OP_READ, '0, 1'b0, 9'h000, 1'b0, '0);
		for (i = 0; i < 6; i++)
			issue_word(OP_READ, '0, 1'b0, READ_W'($urandom), 1'b0, '0);
		key = shadow_col[$urandom_range(0, MAX_ENTRIES - 1)];
		issue_word(OP_TOGGLE, key, 1'b1, '0, 1'b0, '0);
		issue_word(OP_READ, '0, 1'b0, 9'h1FF, 1'b0, '0);
		issue_word(OP_TOGGLE, key, 1'b0, '0, 1'b0, '0);
		issue_word(OP_TOGGLE, key_t'($urandom), 1'b0, '0, 1'b0, '0);
		for (i = 0; i < 8; i++)
			issue_word(OP_TOGGLE, shadow_col[$urandom_range(0, shadow_cnt - 1)],
				1'($urandom), '0, 1'b0, '0);
		issue_word(OP_READ, '0, 1'b0, READ_W'(shadow_cnt - 1), 1'b0, '0);

		random_traffic(110);

		// Relation ends back to back on a fresh column.
		issue_word(OP_CLEAR, '0, 1'b0, '0, 1'b0, '0);
		no_idle = 1'b1;
		for (i = 0; i < BURST_WORDS; i++)
			issue_word(OP_TOGGLE, pick_key(), 1'b1, '0, 1'b0, '0);
		no_idle = 1'b0;

		random_traffic(110);

		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/gsca_pkg.sv
src/gsca_cell.sv
src/gsca_group.sv
src/gsca_ctrl.sv
src/gf2_sparse_column_accumulator.sv
src/gsca_checker.sv
sim/gf2_sparse_column_accumulator_tb.sv
